// File: rtl/spgd_pkg.sv
package spgd_pkg;

   localparam int AddrW   = 6;
   localparam int HeightW = 3;
   localparam int TopW    = 24;
   localparam int LostW   = 14;

   localparam logic [TopW-1:0]  TOPPLE_MAX = '1;
   localparam logic [LostW-1:0] LOST_MAX   = '1;

   typedef enum logic [1:0] {
      OP_DROP = 2'd0,
      OP_READ = 2'd1,
      OP_LOAD = 2'd2
   } spgd_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_SUM,
      ST_DONE
   } spgd_state_type;

   // broadcast to every cell; clear restarts the per-row counts
   typedef struct packed {
      logic             clear;
      logic             drop;
      logic             load;
      logic [AddrW-1:0] row;
      logic [AddrW-1:0] col;
      logic [1:0]       value;
   } spgd_cmd_type;

   typedef struct packed {
      logic             any_topple;
      logic [TopW-1:0]  topple_acc;
      logic [LostW-1:0] lost_acc;
      logic [1:0]       read_height;
   } spgd_row_stat_type;

endpackage

// File: rtl/spgd_if.sv
interface spgd_req_if import spgd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       opcode;
   logic [AddrW-1:0] row_index;
   logic [AddrW-1:0] column_index;
   logic [1:0]       load_value;

   modport source (output valid, opcode, row_index, column_index, load_value, input ready);
   modport sink   (input valid, opcode, row_index, column_index, load_value, output ready);
endinterface

interface spgd_rsp_if import spgd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       cell_height;
   logic [TopW-1:0]  topple_total;
   logic [LostW-1:0] grains_lost;
   logic             in_range;

   modport source (output valid, cell_height, topple_total, grains_lost, in_range, input ready);
   modport sink   (input valid, cell_height, topple_total, grains_lost, in_range, output ready);
endinterface

// File: rtl/spgd_cell.sv
module spgd_cell import spgd_pkg::*; #(
   parameter int ROW = 0,
   parameter int COL = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  spgd_cmd_type cmd,
   input  logic         north_topple,
   input  logic         south_topple,
   input  logic         west_topple,
   input  logic         east_topple,
   output logic         topple,
   output logic [1:0]   height
);

   logic [HeightW-1:0] height_ff;
   logic [HeightW-1:0] height_in;
   logic               hit;

   assign hit = (cmd.row == AddrW'(ROW)) && (cmd.col == AddrW'(COL));

   // a toppling cell drops four grains: that is simply its top bit
   always_comb begin
      height_in = {1'b0, height_ff[1:0]}
                + HeightW'(north_topple) + HeightW'(south_topple)
                + HeightW'(west_topple)  + HeightW'(east_topple)
                + HeightW'(cmd.drop && hit);
      if (cmd.load && hit) begin
         height_in = {1'b0, cmd.value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= '0;
      end else begin
         height_ff <= height_in;
      end
   end

   assign topple = height_ff[HeightW-1];
   assign height = height_ff[1:0];

endmodule

// File: rtl/spgd_row.sv
module spgd_row import spgd_pkg::*; #(
   parameter int ROW       = 0,
   parameter int GRID_ROWS = 16,
   parameter int GRID_COLS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spgd_cmd_type         cmd,
   input  logic [AddrW-1:0]     read_col,
   input  logic [GRID_COLS-1:0] north_topple,
   input  logic [GRID_COLS-1:0] south_topple,
   output logic [GRID_COLS-1:0] topple_vec,
   output spgd_row_stat_type    stat
);

   localparam int CntW      = $clog2(GRID_COLS + 1);
   localparam int LostStepW = $clog2(2 * GRID_COLS + 3);

   logic [GRID_COLS-1:0] west_vec;
   logic [GRID_COLS-1:0] east_vec;
   logic [1:0]           height_vec [GRID_COLS];
   logic [CntW-1:0]      pop;
   logic [LostStepW-1:0] lost_step;
   logic [1:0]           read_height;
   logic [TopW:0]        topple_sum;
   logic [LostW:0]       lost_sum;
   logic [TopW-1:0]      topple_acc_ff, topple_acc_in;
   logic [LostW-1:0]     lost_acc_ff, lost_acc_in;

   assign west_vec = topple_vec << 1;
   assign east_vec = topple_vec >> 1;

   for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
      spgd_cell #(
         .ROW (ROW),
         .COL (c)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .north_topple (north_topple[c]),
         .south_topple (south_topple[c]),
         .west_topple  (west_vec[c]),
         .east_topple  (east_vec[c]),
         .topple       (topple_vec[c]),
         .height       (height_vec[c])
      );
   end

   // edge cells lose one grain per missing neighbor
   always_comb begin
      pop = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
         pop = pop + CntW'(topple_vec[c]);
      end
      lost_step = LostStepW'(topple_vec[0]) + LostStepW'(topple_vec[GRID_COLS-1]);
      if (ROW == 0) begin
         lost_step = lost_step + LostStepW'(pop);
      end
      if (ROW == GRID_ROWS - 1) begin
         lost_step = lost_step + LostStepW'(pop);
      end
      read_height = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
         if (read_col == AddrW'(c)) begin
            read_height = height_vec[c];
         end
      end
   end

   always_comb begin
      topple_sum = (TopW+1)'(topple_acc_ff) + (TopW+1)'(pop);
      lost_sum   = (LostW+1)'(lost_acc_ff) + (LostW+1)'(lost_step);
      if (cmd.clear) begin
         topple_acc_in = '0;
         lost_acc_in   = '0;
      end else begin
         topple_acc_in = topple_sum[TopW] ? TOPPLE_MAX : topple_sum[TopW-1:0];
         lost_acc_in   = lost_sum[LostW] ? LOST_MAX : lost_sum[LostW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         topple_acc_ff <= '0;
         lost_acc_ff   <= '0;
      end else begin
         topple_acc_ff <= topple_acc_in;
         lost_acc_ff   <= lost_acc_in;
      end
   end

   assign stat.any_topple  = |topple_vec;
   assign stat.topple_acc  = topple_acc_ff;
   assign stat.lost_acc    = lost_acc_ff;
   assign stat.read_height = read_height;

endmodule

// File: rtl/sandpile_grain_drop.sv
// channel  dir  handshake          payload
// req_bus  in   valid/ready        opcode, row_index, column_index, load_value
// rsp_bus  out  valid/ready        cell_height, topple_total, grains_lost, in_range
//
// One item at a time. Read, load and an outside drop go from transfer straight to ST_DONE, which
// loads the result into the output register. A drop inside the grid first passes through ST_SETTLE,
// where parallel topple waves run over the cell array until the grid is quiet, then through ST_SUM,
// where one row count per cycle is folded into the totals. Reset (synchronous) zeroes every cell
// and count. A stalled result holds in the output register; the next request is taken meanwhile.
module sandpile_grain_drop import spgd_pkg::*; #(
   parameter int GRID_ROWS = 16,
   parameter int GRID_COLS = 16
) (
   input  logic       clock,
   input  logic       reset,
   spgd_req_if.sink   req_bus,
   spgd_rsp_if.source rsp_bus
);

   localparam int RowIdxW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

   spgd_state_type    state_ff, state_in;
   spgd_cmd_type      cmd;
   logic [GRID_COLS-1:0] topple_vec [GRID_ROWS];
   logic [GRID_COLS-1:0] north_vec  [GRID_ROWS];
   logic [GRID_COLS-1:0] south_vec  [GRID_ROWS];
   spgd_row_stat_type stat [GRID_ROWS];
   spgd_row_stat_type sel_stat;

   logic              accept;
   logic              inside_req;
   logic              any_topple;
   logic [1:0]        read_height;
   logic [TopW:0]     topple_add;
   logic [LostW:0]    lost_add;

   logic [AddrW-1:0]  row_ff, row_in;
   logic [AddrW-1:0]  col_ff, col_in;
   logic              inside_ff, inside_in;
   logic [RowIdxW-1:0] idx_ff, idx_in;
   logic [TopW-1:0]   topple_sum_ff, topple_sum_in;
   logic [LostW-1:0]  lost_sum_ff, lost_sum_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_height_ff, rsp_height_in;
   logic [TopW-1:0]   rsp_topple_ff, rsp_topple_in;
   logic [LostW-1:0]  rsp_lost_ff, rsp_lost_in;
   logic              rsp_range_ff, rsp_range_in;

   assign req_bus.ready = (state_ff == ST_IDLE) && !reset;
   assign accept        = req_bus.valid && req_bus.ready;
   assign inside_req    = ({1'b0, req_bus.row_index} < (AddrW+1)'(GRID_ROWS))
                       && ({1'b0, req_bus.column_index} < (AddrW+1)'(GRID_COLS));

   assign cmd.clear = accept;
   assign cmd.drop  = accept && inside_req && (req_bus.opcode == OP_DROP);
   assign cmd.load  = accept && inside_req && (req_bus.opcode == OP_LOAD);
   assign cmd.row   = req_bus.row_index;
   assign cmd.col   = req_bus.column_index;
   assign cmd.value = req_bus.load_value;

   for (genvar r = 0; r < GRID_ROWS; r++) begin : g_row
      if (r > 0) begin : g_north
         assign north_vec[r] = topple_vec[r-1];
      end else begin : g_north_edge
         assign north_vec[r] = '0;
      end
      if (r < GRID_ROWS - 1) begin : g_south
         assign south_vec[r] = topple_vec[r+1];
      end else begin : g_south_edge
         assign south_vec[r] = '0;
      end

      spgd_row #(
         .ROW       (r),
         .GRID_ROWS (GRID_ROWS),
         .GRID_COLS (GRID_COLS)
      ) u_row (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .read_col     (col_ff),
         .north_topple (north_vec[r]),
         .south_topple (south_vec[r]),
         .topple_vec   (topple_vec[r]),
         .stat         (stat[r])
      );
   end

   always_comb begin
      any_topple  = 1'b0;
      read_height = '0;
      for (int r = 0; r < GRID_ROWS; r++) begin
         any_topple = any_topple | stat[r].any_topple;
         if (row_ff == AddrW'(r)) begin
            read_height = stat[r].read_height;
         end
      end
   end

   assign sel_stat   = stat[idx_ff];
   assign topple_add = (TopW+1)'(topple_sum_ff) + (TopW+1)'(sel_stat.topple_acc);
   assign lost_add   = (LostW+1)'(lost_sum_ff) + (LostW+1)'(sel_stat.lost_acc);

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      inside_in     = inside_ff;
      idx_in        = idx_ff;
      topple_sum_in = topple_sum_ff;
      lost_sum_in   = lost_sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_height_in = rsp_height_ff;
      rsp_topple_in = rsp_topple_ff;
      rsp_lost_in   = rsp_lost_ff;
      rsp_range_in  = rsp_range_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_in        = req_bus.row_index;
               col_in        = req_bus.column_index;
               inside_in     = inside_req;
               topple_sum_in = '0;
               lost_sum_in   = '0;
               state_in      = cmd.drop ? ST_SETTLE : ST_DONE;
            end
         end
         ST_SETTLE: begin
            // cells topple on their own; wait for a quiet grid
            if (!any_topple) begin
               idx_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            topple_sum_in = topple_add[TopW] ? TOPPLE_MAX : topple_add[TopW-1:0];
            lost_sum_in   = lost_add[LostW] ? LOST_MAX : lost_add[LostW-1:0];
            if (idx_ff == RowIdxW'(GRID_ROWS - 1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = inside_ff ? read_height : 2'd0;
               rsp_topple_in = topple_sum_ff;
               rsp_lost_in   = lost_sum_ff;
               rsp_range_in  = inside_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         topple_sum_ff <= '0;
         lost_sum_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         topple_sum_ff <= topple_sum_in;
         lost_sum_ff   <= lost_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      inside_ff     <= inside_in;
      rsp_height_ff <= rsp_height_in;
      rsp_topple_ff <= rsp_topple_in;
      rsp_lost_ff   <= rsp_lost_in;
      rsp_range_ff  <= rsp_range_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.cell_height  = rsp_height_ff;
   assign rsp_bus.topple_total = rsp_topple_ff;
   assign rsp_bus.grains_lost  = rsp_lost_ff;
   assign rsp_bus.in_range     = rsp_range_ff;

   a_done_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !any_topple)
      else $error("result taken from a grid that is still toppling");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_range_ff) |->
         (rsp_height_ff == 2'd0 && rsp_topple_ff == '0 && rsp_lost_ff == '0))
      else $error("outside address gave a nonzero result");

   a_non_drop_done: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.opcode != OP_DROP) |=> (state_ff == ST_DONE))
      else $error("read or load did not go straight to result");

   a_sum_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && $past(state_ff) != ST_SUM) |-> ($past(state_ff) == ST_SETTLE))
      else $error("count gathering started without a settle");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !any_topple)
      else $error("grid toppling while idle");

endmodule
